/* sv/elbs_pkg.sv */
// Shared types and constants for the exponential lower-bound search unit.
// No dependencies; imported by every module of the block.
package elbs_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int KEY_W = 32;
	localparam int OPC_W = 2;
	localparam int IN_TDATA_W = ((OPC_W + KEY_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((CNT_W + 7) / 8) * 8;

	typedef enum logic [OPC_W-1:0] {
		OPC_CLEAR  = 2'd0,
		OPC_APPEND = 2'd1,
		OPC_QUERY  = 2'd2,
		OPC_UNUSED = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [KEY_W-1:0]  key;
	} item_t;

endpackage

/* sv/elbs_front.sv */
// Front end: takes input beats, decodes the opcode and drops unused codes.
// Depends on elbs_pkg; feeds elbs_queue.
module elbs_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: opcode [1:0], key_value [33:2], zero fill above
	input  logic [elbs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output elbs_pkg::item_t                      push_item
);
	import elbs_pkg::*;

	logic     valid_s1;
	item_t    item_s1;
	opcode_t  opc;
	logic     take;
	logic     keep;

	assign opc = opcode_t'(s_axis_tdata[OPC_W-1:0]);
	assign s_axis_tready = !valid_s1 || push_ready;
	assign take = s_axis_tvalid && s_axis_tready;
	assign keep = (opc != OPC_UNUSED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			// drop unused opcodes here so the back end never sees them
			valid_s1 <= take && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.key <= signed'(s_axis_tdata[OPC_W +: KEY_W]);
			unique case (opc)
				OPC_CLEAR:  item_s1.kind <= KIND_CLEAR;
				OPC_APPEND: item_s1.kind <= KIND_APPEND;
				default:    item_s1.kind <= KIND_QUERY;
			endcase
		end
	end

	assign push_valid = valid_s1;
	assign push_item = item_s1;

endmodule

/* sv/elbs_queue.sv */
// Two-entry queue between the decode front end and the search back end.
// Depends on elbs_pkg.
module elbs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  elbs_pkg::item_t  push_item,
	output logic             pop_valid,
	input  logic             pop,
	output elbs_pkg::item_t  pop_item
);
	import elbs_pkg::*;

	item_t        slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   fill_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_item = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

/* sv/elbs_back.sv */
// Back end: holds the value store and runs clear, append and the
// galloping plus binary lower-bound search. Depends on elbs_pkg.
module elbs_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_pop,
	input  elbs_pkg::item_t                      q_item,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata: found_index [CNT_W-1:0], zero fill above
	output logic [elbs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import elbs_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_GALLOP = 6'b000010,
		ST_G_WAIT = 6'b000100,
		ST_BIN    = 6'b001000,
		ST_B_WAIT = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          lo_q;
	logic [CNT_W-1:0]          hi_q;
	logic [CNT_W:0]            probe_q;
	logic [CNT_W-1:0]          mid_q;
	logic signed [KEY_W-1:0]   key_q;
	logic signed [KEY_W-1:0]   mem_q [STORE_DEPTH];
	logic signed [KEY_W-1:0]   rd_q;
	logic                      rd_en;
	logic [ADDR_W-1:0]         rd_addr;
	logic                      wr_en;
	logic [CNT_W:0]            mid_sum;
	logic [CNT_W-1:0]          mid;
	logic                      done;
	logic                      out_valid_q;
	logic [CNT_W-1:0]          out_idx_q;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CNT_W:1];

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = '0;
		q_pop = 1'b0;
		wr_en = 1'b0;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.kind)
						KIND_APPEND: wr_en = (count_q < CNT_W'(STORE_DEPTH));
						KIND_QUERY:  state_d = ST_GALLOP;
						default:     ;
					endcase
				end
			end
			ST_GALLOP: begin
				if (probe_q < {1'b0, count_q}) begin
					rd_en = 1'b1;
					rd_addr = probe_q[ADDR_W-1:0];
					state_d = ST_G_WAIT;
				end else begin
					state_d = ST_BIN;
				end
			end
			ST_G_WAIT: begin
				state_d = (rd_q >= key_q) ? ST_BIN : ST_GALLOP;
			end
			ST_BIN: begin
				if (lo_q < hi_q) begin
					rd_en = 1'b1;
					rd_addr = mid[ADDR_W-1:0];
					state_d = ST_B_WAIT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_B_WAIT: begin
				state_d = ST_BIN;
			end
			ST_DONE: begin
				// hold the answer until the output register is free
				if (!out_valid_q || m_axis_tready) begin
					done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_item.kind == KIND_CLEAR) count_q <= '0;
			if (wr_en) count_q <= count_q + CNT_W'(1);
			if (done) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q <= q_item.key;
				lo_q <= '0;
				hi_q <= count_q;
				probe_q <= (CNT_W + 1)'(1);
			end
			ST_GALLOP: ;
			ST_G_WAIT: begin
				if (rd_q >= key_q) begin
					// bracket the lower bound between half the probe and the probe
					lo_q <= probe_q[CNT_W:1];
					hi_q <= probe_q[CNT_W-1:0];
				end else begin
					probe_q <= {probe_q[CNT_W-1:0], 1'b0};
				end
			end
			ST_BIN: mid_q <= mid;
			ST_B_WAIT: begin
				if (rd_q < key_q) lo_q <= mid_q + CNT_W'(1);
				else hi_q <= mid_q;
			end
			default: ;
		endcase
		if (done) out_idx_q <= lo_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[count_q[ADDR_W-1:0]] <= q_item.key;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = OUT_TDATA_W'(out_idx_q);

	a_read_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> ({1'b0, rd_addr} < (ADDR_W + 1)'(count_q)))
		else $error("store read at or above the element count");

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_B_WAIT) |=> (lo_q <= hi_q))
		else $error("binary search range crossed");

	a_hi_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIN || state_q == ST_DONE) |-> (hi_q <= count_q))
		else $error("search bound above element count");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE && q_valid))
		else $error("queue popped while busy");

	a_done_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("finished query produced no result beat");

endmodule

/* sv/exponential_lower_bound_search_unit.sv */
// Top level of the exponential lower-bound search unit.
// Depends on elbs_pkg, elbs_front, elbs_queue and elbs_back.
//
// Input stream s_axis carries one command per beat: opcode 0 clears the
// store, 1 appends key_value, 2 queries the lower bound of key_value,
// 3 is dropped. Only queries give an output beat on m_axis, holding the
// first index whose element is at least the key, or the element count.
// Commands are decoded into a two-entry queue, so the input keeps taking
// beats while the search engine works or the output is stalled, until the
// queue and the decode register are full. Clear and append are handled in
// the engine's idle state. A query runs from the queue to the output
// register through G galloping probes (up to log2 of the depth) and B
// binary probes (up to one more than that): every probe is one read of
// the store followed by a compare.
// When m_axis stalls, the result holds in the output register; a following
// query finishes its search and waits until that beat is taken.
// Reset empties the store count and all queues; store contents are left
// as they are and are only read below the count.
module exponential_lower_bound_search_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: opcode [1:0], key_value [33:2], zero fill [39:34]
	input  logic [elbs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata: found_index [10:0], zero fill [15:11]
	output logic [elbs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import elbs_pkg::*;

	logic   push_valid;
	logic   push_ready;
	item_t  push_item;
	logic   q_valid;
	logic   q_pop;
	item_t  q_item;

	elbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	elbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	elbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_item        (q_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
